[rtl/ubfp_pkg.sv]
`default_nettype none
package ubfp_pkg;
	localparam int MaxBlock = 256;
	localparam logic [7:0] AckByte = 8'h79;
	localparam logic [7:0] NackByte = 8'h1F;
	localparam logic [7:0] SyncByte = 8'h7F;
	localparam logic [7:0] EraseCmd = 8'h43;
	localparam logic [7:0] EraseCmdN = 8'hBC;
	localparam logic [7:0] EraseAll = 8'hFF;
	localparam logic [7:0] EraseAllN = 8'h00;
	localparam logic [7:0] WriteCmd = 8'h31;
	localparam logic [7:0] WriteCmdN = 8'hCE;
	localparam logic [31:0] FlashBaseRst = 32'h0800_0000;
	localparam logic [11:0] AckTmoRst = 12'd500;
	localparam logic [11:0] SyncTmoRst = 12'd2000;
	localparam logic [7:0] SettleRst = 8'd50;

	typedef enum logic [2:0] {
		FN_START = 3'd0, FN_BYTE = 3'd1, FN_RX = 3'd2, FN_TICK = 3'd3,
		FN_SLOT = 3'd4, FN_END = 3'd5, FN_RSV6 = 3'd6, FN_RSV7 = 3'd7
	} func_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_SYNC_NACK = 4'd1, ST_SYNC_TMO = 4'd2, ST_ER_REF = 4'd3,
		ST_ER_FAIL = 4'd4, ST_WR_REF = 4'd5, ST_ADDR_REJ = 4'd6, ST_DATA_FAIL = 4'd7,
		ST_BAD_SIZE = 4'd8, ST_NOT_OPEN = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		REG_ACK_TMO = 2'd0, REG_SYNC_TMO = 2'd1, REG_SETTLE = 2'd2, REG_BASE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] ack_tmo;
		logic [11:0] sync_tmo;
		logic [7:0] settle;
		logic [31:0] flash_base;
	} cfg_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] data_byte;
		logic last;
	} in_t;

	typedef struct packed {
		logic tx_valid;
		logic [7:0] tx_byte;
		logic boot0_level;
		logic reset_level;
		logic busy_res;
		logic status_valid;
		logic [3:0] status;
		logic [31:0] next_address;
	} out_t;
endpackage
`default_nettype wire

[rtl/ubfp_if.sv]
`default_nettype none
interface ubfp_in_if;
	import ubfp_pkg::*;
	logic valid;
	logic ready;
	logic [2:0] func;
	logic [7:0] data_byte;
	logic last;
	modport source(output valid, func, data_byte, last, input ready);
	modport sink(input valid, func, data_byte, last, output ready);
endinterface

interface ubfp_out_if;
	logic valid;
	logic ready;
	logic tx_valid;
	logic [7:0] tx_byte;
	logic boot0_level;
	logic reset_level;
	logic busy_res;
	logic status_valid;
	logic [3:0] status;
	logic [31:0] next_address;
	modport source(output valid, tx_valid, tx_byte, boot0_level, reset_level, busy_res,
		status_valid, status, next_address, input ready);
	modport sink(input valid, tx_valid, tx_byte, boot0_level, reset_level, busy_res,
		status_valid, status, next_address, output ready);
endinterface
`default_nettype wire

[rtl/ubfp_cfg.sv]
`default_nettype none
module ubfp_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output ubfp_pkg::cfg_t cfg
);
	import ubfp_pkg::*;
	cfg_t cfg_q;
	reg_idx_t idx;
	assign idx = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// write a register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_tmo <= AckTmoRst;
			cfg_q.sync_tmo <= SyncTmoRst;
			cfg_q.settle <= SettleRst;
			cfg_q.flash_base <= FlashBaseRst;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (idx)
				REG_ACK_TMO: cfg_q.ack_tmo <= pwdata[11:0];
				REG_SYNC_TMO: cfg_q.sync_tmo <= pwdata[11:0];
				REG_SETTLE: cfg_q.settle <= pwdata[7:0];
				REG_BASE: cfg_q.flash_base <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_ACK_TMO: prdata = {20'd0, cfg_q.ack_tmo};
			REG_SYNC_TMO: prdata = {20'd0, cfg_q.sync_tmo};
			REG_SETTLE: prdata = {24'd0, cfg_q.settle};
			REG_BASE: prdata = cfg_q.flash_base;
			default: prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

[rtl/ubfp_seq.sv]
`default_nettype none
module ubfp_seq #(
	parameter int MAX_BLOCK = ubfp_pkg::MaxBlock
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ubfp_pkg::cfg_t cfg,
	input wire logic in_fire,
	input wire ubfp_pkg::in_t in_item,
	input wire logic stall,
	output logic out_valid,
	output ubfp_pkg::out_t out_item
);
	import ubfp_pkg::*;
	localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int CW = $clog2(MAX_BLOCK + 2);
	localparam logic [CW-1:0] MaxC = CW'(MAX_BLOCK);
	localparam logic [CW-1:0] OvfC = CW'(MAX_BLOCK + 1);

	typedef enum logic [4:0] {
		PH_IDLE, PH_S_RLOW, PH_S_SETTLE, PH_SYNC_TX, PH_SYNC_WAIT, PH_ER1_TX, PH_ER1_WAIT,
		PH_ER2_TX, PH_ER2_WAIT, PH_WC_TX, PH_WC_WAIT, PH_WA_TX, PH_WA_WAIT, PH_WD_TX,
		PH_WD_WAIT, PH_E_RLOW, PH_E_SETTLE
	} phase_t;

	phase_t phase_q, ph_n;
	logic [11:0] timer_q, tm_n;
	logic [CW-1:0] cnt_q, cnt_n, idx_q, idx_n;
	logic [7:0] xor_q, xor_n;
	logic [31:0] addr_q, addr_n;
	logic open_q, open_n, boot_q, boot_n, rst_q, rst_n;
	logic [7:0] mem [MAX_BLOCK];
	logic [7:0] rd_q;
	logic wr_en;
	logic [AW-1:0] wr_a, rd_a;
	logic txv, stv;
	logic [7:0] txb;
	status_t stc;
	logic pend_q;
	func_t fn;

	// the data byte at send_index is prefetched: read address follows next index
	assign fn = func_t'(in_item.func);
	assign wr_a = cnt_q[AW-1:0];
	assign rd_a = AW'(idx_n - CW'(1));

	function automatic logic is_ack(phase_t p);
		return p == PH_ER1_WAIT || p == PH_ER2_WAIT || p == PH_WC_WAIT ||
			p == PH_WA_WAIT || p == PH_WD_WAIT;
	endfunction

	// next-state logic for one item
	always_comb begin
		ph_n = phase_q; tm_n = timer_q; cnt_n = cnt_q; idx_n = idx_q; xor_n = xor_q;
		addr_n = addr_q; open_n = open_q; boot_n = boot_q; rst_n = rst_q;
		txv = 1'b0; txb = 8'd0; stv = 1'b0; stc = ST_OK; wr_en = 1'b0;
		if (in_fire) begin
			case (fn)
				FN_START: if (phase_q == PH_IDLE) begin
					addr_n = cfg.flash_base; cnt_n = '0;
					if (open_q) begin stv = 1'b1; stc = ST_OK; end
					else begin boot_n = 1'b1; rst_n = 1'b0; ph_n = PH_S_RLOW; end
				end
				FN_BYTE: if (phase_q == PH_IDLE) begin
					if (cnt_q < MaxC) begin wr_en = 1'b1; cnt_n = cnt_q + CW'(1); end
					else cnt_n = OvfC;
					if (in_item.last) begin
						if (!open_q) begin cnt_n = '0; stv = 1'b1; stc = ST_NOT_OPEN; end
						else if (cnt_n > MaxC) begin
							cnt_n = '0; stv = 1'b1; stc = ST_BAD_SIZE;
						end else if (addr_q < cfg.flash_base) begin
							cnt_n = '0; stv = 1'b1; stc = ST_ADDR_REJ;
						end else begin idx_n = '0; xor_n = '0; ph_n = PH_WC_TX; end
					end
				end
				FN_RX: if (in_item.data_byte != 8'd0) begin
					if (phase_q == PH_SYNC_WAIT) begin
						if (in_item.data_byte == AckByte) begin
							idx_n = '0; ph_n = PH_ER1_TX;
						end else begin
							stv = 1'b1; ph_n = PH_IDLE;
							stc = (in_item.data_byte == NackByte) ? ST_SYNC_NACK : ST_SYNC_TMO;
						end
					end else if (is_ack(phase_q)) begin
						if (in_item.data_byte == AckByte) begin
							idx_n = '0; xor_n = '0;
							case (phase_q)
								PH_ER1_WAIT: ph_n = PH_ER2_TX;
								PH_ER2_WAIT: begin open_n = 1'b1; ph_n = PH_IDLE; stv = 1'b1; end
								PH_WC_WAIT: ph_n = PH_WA_TX;
								PH_WA_WAIT: ph_n = PH_WD_TX;
								default: begin
									addr_n = addr_q + 32'(cnt_q); cnt_n = '0;
									ph_n = PH_IDLE; stv = 1'b1;
								end
							endcase
						end else begin
							stv = 1'b1; ph_n = PH_IDLE; cnt_n = '0;
							case (phase_q)
								PH_ER1_WAIT: stc = ST_ER_REF;
								PH_ER2_WAIT: stc = ST_ER_FAIL;
								PH_WC_WAIT: stc = ST_WR_REF;
								PH_WA_WAIT: stc = ST_ADDR_REJ;
								default: stc = ST_DATA_FAIL;
							endcase
						end
					end
				end
				FN_TICK: begin
					if (phase_q == PH_S_RLOW || phase_q == PH_E_RLOW) begin
						rst_n = 1'b1; tm_n = {4'd0, cfg.settle};
						ph_n = (phase_q == PH_S_RLOW) ? PH_S_SETTLE : PH_E_SETTLE;
					end else if (phase_q == PH_S_SETTLE || phase_q == PH_E_SETTLE ||
						phase_q == PH_SYNC_WAIT || is_ack(phase_q)) begin
						if (timer_q > 12'd1) tm_n = timer_q - 12'd1;
						else begin
							tm_n = '0;
							case (phase_q)
								PH_S_SETTLE: ph_n = PH_SYNC_TX;
								PH_E_SETTLE: begin ph_n = PH_IDLE; stv = 1'b1; end
								PH_SYNC_WAIT: begin ph_n = PH_IDLE; stv = 1'b1; stc = ST_SYNC_TMO; end
								default: begin
									stv = 1'b1; ph_n = PH_IDLE; cnt_n = '0;
									case (phase_q)
										PH_ER1_WAIT: stc = ST_ER_REF;
										PH_ER2_WAIT: stc = ST_ER_FAIL;
										PH_WC_WAIT: stc = ST_WR_REF;
										PH_WA_WAIT: stc = ST_ADDR_REJ;
										default: stc = ST_DATA_FAIL;
									endcase
								end
							endcase
						end
					end
				end
				FN_SLOT: begin
					case (phase_q)
						PH_SYNC_TX: begin
							txv = 1'b1; txb = SyncByte; ph_n = PH_SYNC_WAIT; tm_n = cfg.sync_tmo;
						end
						PH_ER1_TX, PH_ER2_TX, PH_WC_TX: begin
							txv = 1'b1;
							case (phase_q)
								PH_ER1_TX: txb = (idx_q != '0) ? EraseCmdN : EraseCmd;
								PH_ER2_TX: txb = (idx_q != '0) ? EraseAllN : EraseAll;
								default: txb = (idx_q != '0) ? WriteCmdN : WriteCmd;
							endcase
							if (idx_q != '0) begin
								tm_n = cfg.ack_tmo;
								case (phase_q)
									PH_ER1_TX: ph_n = PH_ER1_WAIT;
									PH_ER2_TX: ph_n = PH_ER2_WAIT;
									default: ph_n = PH_WC_WAIT;
								endcase
							end else idx_n = CW'(1);
						end
						PH_WA_TX: begin
							txv = 1'b1;
							if (idx_q < CW'(4)) begin
								case (idx_q[1:0])
									2'd0: txb = addr_q[31:24];
									2'd1: txb = addr_q[23:16];
									2'd2: txb = addr_q[15:8];
									default: txb = addr_q[7:0];
								endcase
								xor_n = xor_q ^ txb; idx_n = idx_q + CW'(1);
							end else begin
								txb = xor_q; ph_n = PH_WA_WAIT; tm_n = cfg.ack_tmo;
							end
						end
						PH_WD_TX: begin
							txv = 1'b1;
							if (idx_q == '0) begin
								txb = 8'(cnt_q - CW'(1)); xor_n = txb; idx_n = CW'(1);
							end else if (idx_q <= cnt_q) begin
								txb = rd_q; xor_n = xor_q ^ rd_q; idx_n = idx_q + CW'(1);
							end else begin
								txb = xor_q; ph_n = PH_WD_WAIT; tm_n = cfg.ack_tmo;
							end
						end
						default: ;
					endcase
				end
				FN_END: begin
					open_n = 1'b0; cnt_n = '0; addr_n = cfg.flash_base; boot_n = 1'b0;
					rst_n = 1'b0; tm_n = '0; ph_n = PH_E_RLOW;
				end
				default: ;
			endcase
		end
	end

	// block buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_a] <= in_item.data_byte;
		rd_q <= mem[rd_a];
	end

	// hold state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; timer_q <= '0; cnt_q <= '0; idx_q <= '0; xor_q <= '0;
			addr_q <= FlashBaseRst; open_q <= 1'b0; boot_q <= 1'b0; rst_q <= 1'b1;
			pend_q <= 1'b0;
		end else begin
			phase_q <= ph_n; timer_q <= tm_n; cnt_q <= cnt_n; idx_q <= idx_n; xor_q <= xor_n;
			addr_q <= addr_n; open_q <= open_n; boot_q <= boot_n; rst_q <= rst_n;
			if (in_fire) pend_q <= 1'b1;
			else if (!stall) pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_item.tx_valid <= txv;
			out_item.tx_byte <= txb;
			out_item.boot0_level <= boot_n;
			out_item.reset_level <= rst_n;
			out_item.busy_res <= ph_n != PH_IDLE;
			out_item.status_valid <= stv;
			out_item.status <= stv ? stc : ST_OK;
			out_item.next_address <= addr_n;
		end
	end
	assign out_valid = pend_q;

	// a write starts only from the command phase with a nonempty buffer
	a_wc: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_WC_TX && ph_n == PH_WC_TX) |-> (cnt_n != '0 && cnt_n <= MaxC))
		else $error("write entered with bad count");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WD_TX) |-> (idx_q <= cnt_q + CW'(1)))
		else $error("send index past block");
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WC_TX) |-> open_q)
		else $error("write without open session");
endmodule
`default_nettype wire

[rtl/uart_bootloader_flash_programmer_unit.sv]
`default_nettype none
// Host sequencer for a serial bootloader: one item (command, block byte,
// received byte, ms tick or transmit slot) is taken every clock and gives its
// result in the next cycle in the output register; the output register holds
// while the sink stalls and a new item is taken when it drains in the same
// cycle. Block bytes go into a 1-read/1-write buffer memory whose registered
// read is prefetched one slot ahead, so data bytes also go out one per slot.
module uart_bootloader_flash_programmer_unit #(
	parameter int MAX_BLOCK = ubfp_pkg::MaxBlock
) (
	input wire logic clk,
	input wire logic arst_n,
	ubfp_in_if.sink in_ch,
	ubfp_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ubfp_pkg::*;
	cfg_t cfg;
	in_t in_item;
	out_t out_item;
	logic in_fire, out_valid, stall;

	assign stall = out_valid && !out_ch.ready;
	assign in_ch.ready = !stall;
	assign in_fire = in_ch.valid && !stall;
	assign in_item = '{func: in_ch.func, data_byte: in_ch.data_byte, last: in_ch.last};

	ubfp_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.pready, .cfg);

	ubfp_seq #(.MAX_BLOCK(MAX_BLOCK)) u_seq (.clk, .arst_n, .cfg, .in_fire, .in_item,
		.stall, .out_valid, .out_item);

	// drive the result channel
	assign out_ch.valid = out_valid;
	assign out_ch.tx_valid = out_item.tx_valid;
	assign out_ch.tx_byte = out_item.tx_byte;
	assign out_ch.boot0_level = out_item.boot0_level;
	assign out_ch.reset_level = out_item.reset_level;
	assign out_ch.busy_res = out_item.busy_res;
	assign out_ch.status_valid = out_item.status_valid;
	assign out_ch.status = out_item.status;
	assign out_ch.next_address = out_item.next_address;
endmodule
`default_nettype wire
